[rtl/jde_pkg.sv]
// Shared types and constants for the joystick deadband and expo conditioner.
`timescale 1ns / 1ps

package jde_pkg;

    // Field and register widths.
    localparam int ADC_BITS_DEF = 12;
    localparam int SAMPLE_W     = 12;
    localparam int CAL_W        = 12;
    localparam int EXPO_W       = 10;
    localparam int AXIS_W       = 8;
    localparam int MAG_W        = 7;
    localparam int FRAC_W       = 30;
    localparam int SIGNED_W     = 15;

    // Widths and iteration counts of the shared divider and square-root unit.
    localparam int DIV_W        = 42;
    localparam int DEN_W        = 13;
    localparam int SQRT_STEPS   = 30;
    localparam int CNT_W        = 6;
    localparam int ROOT_COUNT   = 8;
    localparam int IDX_W        = 4;

    // Linear mode holds for an exponent of 1.0 or less (Q2.8).
    localparam int EXPO_ONE     = 256;
    localparam int FULL_SCALE   = 100;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_DEAD_BAND  = 4'd0,
        REG_CENTER_X   = 4'd1,
        REG_CENTER_Y   = 4'd2,
        REG_MINIMUM_X  = 4'd3,
        REG_MAXIMUM_X  = 4'd4,
        REG_MINIMUM_Y  = 4'd5,
        REG_MAXIMUM_Y  = 4'd6,
        REG_EXPO_POWER = 4'd7
    } cfg_reg_t;

    // Classification of one axis sample.
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_LIN,
        CLS_CURVE
    } cls_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_DONE,
        OP_ACC_INIT,
        OP_MUL_ACC,
        OP_MUL_SQ,
        OP_MUL_SQACC,
        OP_ROUND,
        OP_STORE,
        OP_OUTPUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             axis;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        cls_t              cls;
        logic [EXPO_W-1:0] expo;
    } status_t;

endpackage

[rtl/jde_ctrl.sv]
// Controller state machine that sequences the per-axis conditioning steps.
`timescale 1ns / 1ps

module jde_ctrl
    import jde_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_DIV_END,
        S_SQ_INIT,
        S_SQ,
        S_SQ_END,
        S_ACC_INIT,
        S_MUL,
        S_MUL_SQ,
        S_MUL_SQACC,
        S_ROUND,
        S_STORE,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic             axis_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] j_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Command decode for the current step.
    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.axis = axis_reg;
        cmd.idx  = k_reg;
        case (state_reg)
            S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_SETUP:     cmd.op = OP_SETUP;
            S_DIV:       cmd.op = OP_DIV_STEP;
            S_DIV_END:   cmd.op = OP_DIV_DONE;
            S_SQ_INIT:   cmd.op = OP_SQRT_INIT;
            S_SQ:        cmd.op = OP_SQRT_STEP;
            S_SQ_END:    cmd.op = OP_SQRT_DONE;
            S_ACC_INIT:  cmd.op = OP_ACC_INIT;
            S_MUL:
            begin
                cmd.op  = status.expo[j_reg] ? OP_MUL_ACC : OP_NONE;
                cmd.idx = (j_reg == IDX_W'(ROOT_COUNT)) ? '0 : IDX_W'(ROOT_COUNT) - j_reg;
            end
            S_MUL_SQ:    cmd.op = OP_MUL_SQ;
            S_MUL_SQACC: cmd.op = status.expo[EXPO_W-1] ? OP_MUL_SQACC : OP_NONE;
            S_ROUND:     cmd.op = OP_ROUND;
            S_STORE:     cmd.op = OP_STORE;
            S_OUT:       cmd.op = out_free ? OP_OUTPUT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // State, counters and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    cnt_reg <= '0;
                    if (status.cls == CLS_ZERO || status.cls == CLS_FULL)
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_W - 1))
                    begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END:
                begin
                    k_reg     <= IDX_W'(1);
                    state_reg <= (status.cls == CLS_LIN) ? S_STORE : S_SQ_INIT;
                end
                S_SQ_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= S_SQ_END;
                    end
                end
                S_SQ_END:
                begin
                    if (k_reg == IDX_W'(ROOT_COUNT))
                    begin
                        state_reg <= S_ACC_INIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SQ_INIT;
                    end
                end
                S_ACC_INIT:
                begin
                    j_reg     <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (j_reg == IDX_W'(ROOT_COUNT))
                    begin
                        state_reg <= S_MUL_SQ;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_MUL_SQ:    state_reg <= S_MUL_SQACC;
                S_MUL_SQACC: state_reg <= S_ROUND;
                S_ROUND:     state_reg <= S_STORE;
                S_STORE:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/jde_dp.sv]
// Datapath: configuration registers, classification, divider, square root and curve.
`timescale 1ns / 1ps

module jde_dp
    import jde_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [CAL_W-1:0]    cfg_data,
    input  logic [SAMPLE_W-1:0] sample_x,
    input  logic [SAMPLE_W-1:0] sample_y,
    input  cmd_t                cmd,
    output status_t             status,
    output logic [AXIS_W-1:0]   axis_x,
    output logic [AXIS_W-1:0]   axis_y,
    output logic                moved
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [FRAC_W:0]     Q_ONE       = (FRAC_W+1)'(1) << FRAC_W;
    localparam int                  RND_W       = FRAC_W + 8;

    // Configuration and previous-output state.
    logic [CAL_W-1:0]  dead_band_reg, center_x_reg, center_y_reg;
    logic [CAL_W-1:0]  minimum_x_reg, maximum_x_reg, minimum_y_reg, maximum_y_reg;
    logic [EXPO_W-1:0] expo_power_reg;
    logic [AXIS_W-1:0] prev_x_reg, prev_y_reg;
    logic              moved_reg;

    // Working registers.
    logic [SAMPLE_W-1:0] sx_reg, sy_reg;
    logic                sign_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [2*FRAC_W-1:0] sq_v_reg;
    logic [FRAC_W+1:0]   sq_rem_reg;
    logic [FRAC_W-1:0]   sq_root_reg;
    logic [FRAC_W-1:0]   last_reg;
    logic [FRAC_W-1:0]   roots_reg [ROOT_COUNT+1];
    logic [FRAC_W-1:0]   msq_reg;
    logic [FRAC_W:0]     acc_reg;
    logic [AXIS_W-1:0]   ax_reg, ay_reg;

    // Classification of the selected axis.
    logic [SAMPLE_W-1:0]       smp;
    logic [CAL_W-1:0]          cen, cal_lo, cal_hi;
    logic signed [SIGNED_W-1:0] s_v, c_v, lo_v, hi_v, num_v, span_v;
    logic                      above, in_zone;
    logic [CAL_W-1:0]          num12, span12;
    cls_t                      cls;

    always_comb
    begin
        smp    = cmd.axis ? sy_reg : sx_reg;
        cen    = cmd.axis ? center_y_reg : center_x_reg;
        cal_lo = cmd.axis ? minimum_y_reg : minimum_x_reg;
        cal_hi = cmd.axis ? maximum_y_reg : maximum_x_reg;
        s_v    = signed'(SIGNED_W'(smp));
        c_v    = signed'(SIGNED_W'(cen));
        lo_v   = c_v - signed'(SIGNED_W'(dead_band_reg));
        hi_v   = c_v + signed'(SIGNED_W'(dead_band_reg));
        in_zone = (s_v > lo_v) && (s_v < hi_v);
        above  = (smp > cen);
        if (above)
        begin
            num_v  = s_v - hi_v;
            span_v = signed'(SIGNED_W'(cal_hi)) - hi_v;
        end
        else
        begin
            num_v  = lo_v - s_v;
            span_v = lo_v - signed'(SIGNED_W'(cal_lo));
        end
        num12  = num_v[CAL_W-1:0];
        span12 = span_v[CAL_W-1:0];
        if (in_zone || num_v <= 0)
        begin
            cls = CLS_ZERO;
        end
        else if (span_v <= 0 || num_v >= span_v)
        begin
            cls = CLS_FULL;
        end
        else if (expo_power_reg <= EXPO_W'(EXPO_ONE))
        begin
            cls = CLS_LIN;
        end
        else
        begin
            cls = CLS_CURVE;
        end
    end

    assign status.cls  = cls;
    assign status.expo = expo_power_reg;

    // Divider step: one quotient bit per cycle.
    logic [DEN_W:0] div_trial;
    logic           div_ge;
    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    // Square-root step: one result bit per cycle.
    logic [FRAC_W+3:0] sq_r2, sq_trial;
    logic              sq_ge;
    assign sq_r2    = {sq_rem_reg, sq_v_reg[2*FRAC_W-1 -: 2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_r2 >= sq_trial);

    // Shared multiplier for the exponent product.
    logic [FRAC_W:0]       mul_a;
    logic [FRAC_W-1:0]     mul_b;
    logic [2*FRAC_W:0]     prod;
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = roots_reg[cmd.idx];
        case (cmd.op)
            OP_MUL_SQ:
            begin
                mul_a = {1'b0, roots_reg[0]};
                mul_b = roots_reg[0];
            end
            OP_MUL_SQACC: mul_b = msq_reg;
            default:      mul_b = roots_reg[cmd.idx];
        endcase
    end
    assign prod = mul_a * mul_b;

    // Rounding to hundredths, half up, capped at full scale.
    logic [RND_W-1:0] rnd;
    logic [7:0]       rnd_h;
    assign rnd   = RND_W'(acc_reg) * RND_W'(FULL_SCALE) + (RND_W'(1) << (FRAC_W - 1));
    assign rnd_h = rnd[RND_W-1:FRAC_W];

    // Signed axis value from sign and magnitude.
    logic [AXIS_W-1:0] axv;
    assign axv = sign_reg ? (AXIS_W'(0) - {1'b0, mag_reg}) : {1'b0, mag_reg};

    // Configuration writes and stored outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg  <= '0;
            center_x_reg   <= CAL_W'(2048);
            center_y_reg   <= CAL_W'(2048);
            minimum_x_reg  <= '0;
            maximum_x_reg  <= CAL_W'(4095);
            minimum_y_reg  <= '0;
            maximum_y_reg  <= CAL_W'(4095);
            expo_power_reg <= EXPO_W'(EXPO_ONE);
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            moved_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEAD_BAND:  dead_band_reg  <= cfg_data;
                    REG_CENTER_X:   center_x_reg   <= cfg_data;
                    REG_CENTER_Y:   center_y_reg   <= cfg_data;
                    REG_MINIMUM_X:  minimum_x_reg  <= cfg_data;
                    REG_MAXIMUM_X:  maximum_x_reg  <= cfg_data;
                    REG_MINIMUM_Y:  minimum_y_reg  <= cfg_data;
                    REG_MAXIMUM_Y:  maximum_y_reg  <= cfg_data;
                    REG_EXPO_POWER: expo_power_reg <= cfg_data[EXPO_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.op == OP_OUTPUT)
            begin
                moved_reg  <= (ax_reg != prev_x_reg) || (ay_reg != prev_y_reg);
                prev_x_reg <= ax_reg;
                prev_y_reg <= ay_reg;
            end
        end
    end

    // Working registers, driven by the current operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                sx_reg <= sample_x & SAMPLE_MASK;
                sy_reg <= sample_y & SAMPLE_MASK;
            end
            OP_SETUP:
            begin
                sign_reg <= !above;
                mag_reg  <= (cls == CLS_ZERO) ? '0 : MAG_W'(FULL_SCALE);
                rem_reg  <= '0;
                if (cls == CLS_LIN)
                begin
                    quo_reg <= DIV_W'(num12) * DIV_W'(200) + DIV_W'(span12);
                    den_reg <= {span12, 1'b0};
                end
                else
                begin
                    quo_reg <= {num12, {FRAC_W{1'b0}}};
                    den_reg <= {1'b0, span12};
                end
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? DEN_W'(div_trial - {1'b0, den_reg}) : DEN_W'(div_trial);
                quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
            end
            OP_DIV_DONE:
            begin
                mag_reg      <= quo_reg[MAG_W-1:0];
                roots_reg[0] <= quo_reg[FRAC_W-1:0];
                last_reg     <= quo_reg[FRAC_W-1:0];
            end
            OP_SQRT_INIT:
            begin
                sq_v_reg    <= {last_reg, {FRAC_W{1'b0}}};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                sq_v_reg    <= {sq_v_reg[2*FRAC_W-3:0], 2'b00};
                sq_rem_reg  <= sq_ge ? (FRAC_W+2)'(sq_r2 - sq_trial) : (FRAC_W+2)'(sq_r2);
                sq_root_reg <= {sq_root_reg[FRAC_W-2:0], sq_ge};
            end
            OP_SQRT_DONE:
            begin
                roots_reg[cmd.idx] <= sq_root_reg;
                last_reg           <= sq_root_reg;
            end
            OP_ACC_INIT:  acc_reg <= Q_ONE;
            OP_MUL_ACC:   acc_reg <= (FRAC_W+1)'(prod >> FRAC_W);
            OP_MUL_SQ:    msq_reg <= FRAC_W'(prod >> FRAC_W);
            OP_MUL_SQACC: acc_reg <= (FRAC_W+1)'(prod >> FRAC_W);
            OP_ROUND:
            begin
                mag_reg <= (rnd_h > 8'(FULL_SCALE)) ? MAG_W'(FULL_SCALE) : rnd_h[MAG_W-1:0];
            end
            OP_STORE:
            begin
                if (cmd.axis)
                begin
                    ay_reg <= axv;
                end
                else
                begin
                    ax_reg <= axv;
                end
            end
            default: ;
        endcase
    end

    assign axis_x = prev_x_reg;
    assign axis_y = prev_y_reg;
    assign moved  = moved_reg;

endmodule

[rtl/joystick_axis_deadband_expo.sv]
// Top level of the joystick axis conditioner with deadband and expo curve.
`timescale 1ns / 1ps

// Takes one X/Y converter sample pair per input transaction and returns one
// result transaction with both axis values in hundredths and a moved flag.
// Axes are handled one after the other by a shared bit-serial divider and
// square-root unit. Per axis, a sample in or next to the deadband or at
// full scale takes a setup and a store step, linear mode adds a divide,
// and a curve adds to the divide eight square roots, eleven multiply steps
// and a rounding step. Each pair also takes a step to load it and one
// step for the result. A new pair is taken once the previous result sits
// in the output register, which holds it until the sink takes it.
// Configuration writes are always accepted and must be made while no
// sample pair is in flight.
module joystick_axis_deadband_expo
    import jde_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample_x[11:0], sample_y[23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // axis_x[7:0], axis_y[15:8], moved[16], zero[23:17]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cmd_t              cmd;
    status_t           status;
    logic [AXIS_W-1:0] axis_x, axis_y;
    logic              moved;

    assign cfg_ready = 1'b1;

    jde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    jde_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_x  (s_axis_tdata[11:0]),
        .sample_y  (s_axis_tdata[23:12]),
        .cmd       (cmd),
        .status    (status),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .moved     (moved)
    );

    assign m_axis_tdata = {7'b0, moved, axis_y, axis_x};

endmodule

[rtl/jde_checker.sv]
// Port-level checks for the joystick conditioner and their binding.
`timescale 1ns / 1ps

module jde_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A stalled result transaction keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // Both axis values stay within full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) >= -8'sd100)
            && ($signed(m_axis_tdata[7:0]) <= 8'sd100)
            && ($signed(m_axis_tdata[15:8]) >= -8'sd100)
            && ($signed(m_axis_tdata[15:8]) <= 8'sd100))
        else $error("axis value out of range");

    // Padding bits of the result are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'b0))
        else $error("result padding not zero");

    // A new result appears only at the end of work, while input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

endmodule

bind joystick_axis_deadband_expo jde_checker u_jde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
